@@ rtl/core/ring_buffer_fifo_unit_defines.svh @@
// Assertion macros for the ring buffer FIFO.
// Define ASSERT_OFF to compile the checks out.
`ifndef RING_BUFFER_FIFO_UNIT_DEFINES_SVH
`define RING_BUFFER_FIFO_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define RBF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("ring buffer FIFO check failed");

// Next-cycle implication.
`define RBF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("ring buffer FIFO check failed");

`else

`define RBF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define RBF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

@@ rtl/core/rbf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rbf_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int WORD_BITS  = 32;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CAP_W      = 4;
  localparam int CNT_W      = 4;
  localparam int CMD_W      = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(15);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_COUNT = 2'd3
  } cmd_t;

  typedef struct packed {
    logic                 ok;
    logic [WORD_BITS-1:0] read_data;
    logic                 last;
    logic [CNT_W-1:0]     drained_count;
    logic [CNT_W-1:0]     items_in_queue;
    logic                 queue_empty;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/rbf_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface rbf_in_if;
  logic                          valid;
  logic                          ready;
  logic [rbf_pkg::CMD_W-1:0]     cmd;
  logic [rbf_pkg::WORD_BITS-1:0] push_data;
  logic [rbf_pkg::CNT_W-1:0]     max_items;

  modport source (output valid, cmd, push_data, max_items, input ready);
  modport sink   (input valid, cmd, push_data, max_items, output ready);
endinterface

interface rbf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [rbf_pkg::WORD_BITS-1:0] read_data;
  logic                          last;
  logic [rbf_pkg::CNT_W-1:0]     drained_count;
  logic [rbf_pkg::CNT_W-1:0]     items_in_queue;
  logic                          queue_empty;

  modport source (output valid, ok, read_data, last, drained_count, items_in_queue,
                  queue_empty, input ready);
  modport sink   (input valid, ok, read_data, last, drained_count, items_in_queue,
                  queue_empty, output ready);
endinterface

`default_nettype wire

@@ rtl/core/rbf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rbf_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ring_buffer_fifo_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "ring_buffer_fifo_unit_defines.svh"

// Channel   Dir  Payload                                        Transfer
// req       in   cmd, push_data, max_items                      valid & ready
// rsp       out  ok, read_data, last, drained_count,            valid & ready
//                items_in_queue, queue_empty
// cfg       in   cfg_data (capacity)                            cfg_we
//
// Push, failed pop/drain and count: the result goes straight into the output register when it is free.
// Pop: the slot RAM read is registered, then the word is loaded into the output register.
// Drain of n words: one RAM read and one result per cycle while rsp is not stalled.
// Reset (synchronous) empties the ring and sets capacity to 15; slot contents stay.
// A stalled rsp holds the output register; req waits only while a command is in work.

module ring_buffer_fifo_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rbf_pkg::CAP_W-1:0] cfg_data,
  rbf_in_if.sink                    req,
  rbf_out_if.source                 rsp
);

  localparam int NW = rbf_pkg::IDX_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EMIT} state_t;

  function automatic logic [rbf_pkg::IDX_W-1:0] adv(
    input logic [rbf_pkg::IDX_W-1:0] idx,
    input logic [NW-1:0]             n
  );
    logic [NW-1:0] nx;
    nx = NW'(idx) + NW'(1);
    return (nx >= n) ? '0 : nx[rbf_pkg::IDX_W-1:0];
  endfunction

  function automatic logic [rbf_pkg::CNT_W-1:0] stored(
    input logic [rbf_pkg::IDX_W-1:0] r,
    input logic [rbf_pkg::IDX_W-1:0] w,
    input logic [NW-1:0]             n
  );
    logic [NW-1:0] d;
    if (w >= r) begin
      d = NW'(w) - NW'(r);
    end else begin
      d = n - NW'(r) + NW'(w);
    end
    return rbf_pkg::CNT_W'(d);
  endfunction

  state_t                        state;
  logic [rbf_pkg::CAP_W-1:0]     capacity;
  logic [rbf_pkg::IDX_W-1:0]     rd_idx;
  logic [rbf_pkg::IDX_W-1:0]     wr_idx;
  logic [rbf_pkg::CNT_W-1:0]     cnt;
  logic [rbf_pkg::CNT_W-1:0]     max_lat;
  logic                          is_drain;
  rbf_pkg::res_t                 held;
  rbf_pkg::res_t                 result;
  logic                          out_valid;

  logic [NW-1:0]                 ring_n;
  logic [NW-1:0]                 cap_plus;
  logic                          full;
  logic                          empty;
  logic                          accept;
  logic                          out_free;
  logic                          load_out;
  rbf_pkg::cmd_t                 cmd;
  logic                          needs_read;
  logic                          mem_we;
  logic                          mem_re;
  logic [rbf_pkg::WORD_BITS-1:0] mem_rdata;
  logic [rbf_pkg::IDX_W-1:0]     rd_idx_next;
  logic [rbf_pkg::IDX_W-1:0]     wr_idx_next;
  logic                          rd_last;
  rbf_pkg::res_t                 imm_res;
  rbf_pkg::res_t                 rd_res;
  logic                          idx_ok;

  assign cap_plus = NW'(capacity) + NW'(1);
  assign ring_n   = (cap_plus > NW'(rbf_pkg::SLOT_COUNT)) ? NW'(rbf_pkg::SLOT_COUNT) : cap_plus;
  assign full     = (adv(wr_idx, ring_n) == rd_idx);
  assign empty    = (rd_idx == wr_idx);

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign cmd       = rbf_pkg::cmd_t'(req.cmd);

  assign needs_read = ((cmd == rbf_pkg::CMD_POP) && !empty) ||
                      ((cmd == rbf_pkg::CMD_DRAIN) && !empty && (req.max_items != '0));

  // Load the output register whenever a result is ready and the slot is free.
  assign load_out = out_free && (((state == S_IDLE) && accept && !needs_read) ||
                                 (state == S_READ) || (state == S_EMIT));

  // Drain stops at max_items or when this pop left the ring empty.
  assign rd_last = !is_drain || (cnt == max_lat) || empty;

  assign mem_we = accept && (cmd == rbf_pkg::CMD_PUSH) && !full;
  assign mem_re = (accept && needs_read) || ((state == S_READ) && out_free && !rd_last);

  assign wr_idx_next = mem_we ? adv(wr_idx, ring_n) : wr_idx;
  assign rd_idx_next = mem_re ? adv(rd_idx, ring_n) : rd_idx;

  always_comb begin
    imm_res                = '0;
    imm_res.last           = 1'b1;
    imm_res.ok             = (cmd == rbf_pkg::CMD_PUSH) ? !full : (cmd == rbf_pkg::CMD_COUNT);
    imm_res.items_in_queue = stored(rd_idx, wr_idx_next, ring_n);
    imm_res.queue_empty    = (imm_res.items_in_queue == '0);
  end

  always_comb begin
    rd_res                = '0;
    rd_res.ok             = 1'b1;
    rd_res.read_data      = mem_rdata;
    rd_res.last           = rd_last;
    rd_res.drained_count  = (is_drain && rd_last) ? cnt : '0;
    rd_res.items_in_queue = stored(rd_idx, wr_idx, ring_n);
    rd_res.queue_empty    = empty;
  end

  rbf_ram #(
    .DEPTH (rbf_pkg::SLOT_COUNT),
    .WIDTH (rbf_pkg::WORD_BITS)
  ) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_idx),
    .wdata (req.push_data),
    .re    (mem_re),
    .raddr (rd_idx),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_idx    <= '0;
      wr_idx    <= '0;
      capacity  <= rbf_pkg::CAP_RESET;
    end else begin
      out_valid <= load_out || (out_valid && !rsp.ready);
      // A new capacity sets up a fresh, empty ring.
      rd_idx    <= cfg_we ? '0 : rd_idx_next;
      wr_idx    <= cfg_we ? '0 : wr_idx_next;
      if (cfg_we) begin
        capacity <= cfg_data;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            max_lat  <= req.max_items;
            is_drain <= (cmd == rbf_pkg::CMD_DRAIN);
            cnt      <= rbf_pkg::CNT_W'(1);
            if (needs_read) begin
              state <= S_READ;
            end else if (out_free) begin
              result <= imm_res;
            end else begin
              held  <= imm_res;
              state <= S_EMIT;
            end
          end
        end
        S_READ: begin
          if (out_free) begin
            result <= rd_res;
            if (rd_last) begin
              state <= S_IDLE;
            end else begin
              cnt <= cnt + rbf_pkg::CNT_W'(1);
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            result <= held;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.ok             = result.ok;
  assign rsp.read_data      = result.read_data;
  assign rsp.last           = result.last;
  assign rsp.drained_count  = result.drained_count;
  assign rsp.items_in_queue = result.items_in_queue;
  assign rsp.queue_empty    = result.queue_empty;

  assign idx_ok = (NW'(rd_idx) < ring_n) && (NW'(wr_idx) < ring_n);

  `RBF_ASSERT_IMP(a_idx_in_ring, clk, rst, 1'b1, idx_ok)
  `RBF_ASSERT_IMP(a_fail_is_last, clk, rst, rsp.valid && !rsp.ok, rsp.last)
  `RBF_ASSERT_IMP(a_count_on_last, clk, rst, rsp.valid && !rsp.last, rsp.drained_count == '0)
  `RBF_ASSERT_NXT(a_no_push_in_read, clk, rst, state == S_READ,
                  (wr_idx == $past(wr_idx)) || $past(cfg_we))

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import rbf_pkg::*;

  typedef struct {
    bit                   is_cap;
    logic [CAP_W-1:0]     cap;
    cmd_t                 cmd;
    logic [WORD_BITS-1:0] data;
    logic [CNT_W-1:0]     limit;
    bit                   typed;
    res_t                 want;
  } plan_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;

  rbf_in_if  req_if ();
  rbf_out_if rsp_if ();

  ring_buffer_fifo_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  // Mirror of the ring: storage, indices and capacity.
  logic [WORD_BITS-1:0] slot_mem [SLOT_COUNT];
  int unsigned          rd_ptr;
  int unsigned          wr_ptr;
  int unsigned          cap_now;

  res_t      ring_out [$];
  res_t      awaited_rsp [$];
  int        bad_rsp;
  bit        calm_req;
  bit        calm_rsp;
  plan_row_t plan [32];
  int        plan_len;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned ring_len();
    return (cap_now + 1 > SLOT_COUNT) ? SLOT_COUNT : cap_now + 1;
  endfunction

  function automatic int unsigned step_idx(int unsigned i);
    return (i + 1 >= ring_len()) ? 0 : i + 1;
  endfunction

  function automatic int unsigned fill_level();
    return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : ring_len() - rd_ptr + wr_ptr;
  endfunction

  function automatic res_t make_rsp(logic ok, logic [WORD_BITS-1:0] word, logic last,
                                    int unsigned drained);
    res_t r;
    r.ok             = ok;
    r.read_data      = word;
    r.last           = last;
    r.drained_count  = CNT_W'(drained);
    r.items_in_queue = CNT_W'(fill_level());
    r.queue_empty    = (fill_level() == 0);
    return r;
  endfunction

  // Apply one command to the mirror and collect the results it produces.
  task automatic predict_ring(cmd_t c, logic [WORD_BITS-1:0] d, logic [CNT_W-1:0] lim);
    int unsigned          n;
    logic [WORD_BITS-1:0] word;
    ring_out.delete();
    case (c)
      CMD_PUSH: begin
        if (step_idx(wr_ptr) == rd_ptr) begin
          ring_out.push_back(make_rsp(1'b0, '0, 1'b1, 0));
        end else begin
          slot_mem[wr_ptr] = d;
          wr_ptr = step_idx(wr_ptr);
          ring_out.push_back(make_rsp(1'b1, '0, 1'b1, 0));
        end
      end
      CMD_POP: begin
        if (fill_level() == 0) begin
          ring_out.push_back(make_rsp(1'b0, '0, 1'b1, 0));
        end else begin
          word = slot_mem[rd_ptr];
          rd_ptr = step_idx(rd_ptr);
          ring_out.push_back(make_rsp(1'b1, word, 1'b1, 0));
        end
      end
      CMD_DRAIN: begin
        n = (lim < fill_level()) ? lim : fill_level();
        if (n == 0) ring_out.push_back(make_rsp(1'b0, '0, 1'b1, 0));
        for (int unsigned i = 0; i < n; i++) begin
          word = slot_mem[rd_ptr];
          rd_ptr = step_idx(rd_ptr);
          ring_out.push_back(make_rsp(1'b1, word, i == n - 1, (i == n - 1) ? n : 0));
        end
      end
      default: begin
        ring_out.push_back(make_rsp(1'b1, '0, 1'b1, 0));
      end
    endcase
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_cmd(cmd_t c, logic [WORD_BITS-1:0] d, logic [CNT_W-1:0] lim,
                          bit typed, res_t want);
    int unsigned idle;
    req_if.valid     <= 1'b1;
    req_if.cmd       <= c;
    req_if.push_data <= d;
    req_if.max_items <= lim;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_ring(c, d, lim);
    if (typed) awaited_rsp.push_back(want);
    else foreach (ring_out[i]) awaited_rsp.push_back(ring_out[i]);
    idle = gap_len(calm_req);
    if (idle > 0) begin
      req_if.valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // Write the capacity only once every result has come back.
  task automatic write_capacity(logic [CAP_W-1:0] v);
    req_if.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cap_now = v;
    rd_ptr  = 0;
    wr_ptr  = 0;
  endtask

  task automatic row(cmd_t c, logic [WORD_BITS-1:0] d, logic [CNT_W-1:0] lim);
    plan[plan_len].is_cap = 1'b0;
    plan[plan_len].cap    = '0;
    plan[plan_len].cmd    = c;
    plan[plan_len].data   = d;
    plan[plan_len].limit  = lim;
    plan[plan_len].typed  = 1'b0;
    plan[plan_len].want   = '0;
    plan_len++;
  endtask

  // Single-result row with the result written out by hand.
  task automatic row_chk(cmd_t c, logic [WORD_BITS-1:0] d, logic [CNT_W-1:0] lim, logic ok,
                         logic [WORD_BITS-1:0] rd, logic [CNT_W-1:0] items);
    row(c, d, lim);
    plan[plan_len-1].typed = 1'b1;
    plan[plan_len-1].want  = {ok, rd, 1'b1, {CNT_W{1'b0}}, items, items == 0};
  endtask

  task automatic row_cap(logic [CAP_W-1:0] v);
    row(CMD_COUNT, '0, '0);
    plan[plan_len-1].is_cap = 1'b1;
    plan[plan_len-1].cap    = v;
  endtask

  task automatic note_bad(string what, res_t want, res_t got);
    if (bad_rsp < 10)
      $display("%0t %s: expected ok=%0b data=%h last=%0b drained=%0d items=%0d empty=%0b,",
               $time, what, want.ok, want.read_data, want.last, want.drained_count,
               want.items_in_queue, want.queue_empty,
               " got ok=%0b data=%h last=%0b drained=%0d items=%0d empty=%0b",
               got.ok, got.read_data, got.last, got.drained_count,
               got.items_in_queue, got.queue_empty);
    bad_rsp++;
  endtask

  always @(posedge clk) begin : rsp_check
    res_t got;
    res_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.ok, rsp_if.read_data, rsp_if.last, rsp_if.drained_count,
             rsp_if.items_in_queue, rsp_if.queue_empty};
      if (awaited_rsp.size() == 0) begin
        note_bad("result with nothing pending", got, got);
      end else begin
        want = awaited_rsp.pop_front();
        if (got !== want) note_bad("result mismatch", want, got);
      end
    end
  end

  initial begin : rsp_pace
    int unsigned hold;
    hold = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = gap_len(calm_rsp);
      end
    end
  end

  initial begin : stimulus
    int unsigned          items;
    int unsigned          phase_len;
    int unsigned          hi_pct;
    int unsigned          lo_pct;
    int unsigned          r;
    logic [CAP_W-1:0]     cap_pick;
    cmd_t                 c;
    logic [WORD_BITS-1:0] d;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_data         <= CAP_RESET;
    req_if.valid     <= 1'b0;
    req_if.cmd       <= CMD_COUNT;
    req_if.push_data <= '0;
    req_if.max_items <= '0;
    calm_req = 1'b0;
    calm_rsp = 1'b0;
    bad_rsp  = 0;
    cap_now  = CAP_RESET;
    rd_ptr   = 0;
    wr_ptr   = 0;
    plan_len = 0;

    row_chk(CMD_POP,   '0, 4'd0, 1'b0, '0, 4'd0);
    row_chk(CMD_DRAIN, '0, 4'd5, 1'b0, '0, 4'd0);
    row_chk(CMD_COUNT, '0, 4'd0, 1'b1, '0, 4'd0);
    row_chk(CMD_PUSH, 32'hFFFF_FFFF, 4'd0, 1'b1, '0, 4'd1);
    row_chk(CMD_PUSH, 32'h0000_0000, 4'd15, 1'b1, '0, 4'd2);
    row(CMD_PUSH, 32'h1234_5678, 4'd0);
    // drain with a zero limit pops nothing
    row_chk(CMD_DRAIN, 32'hFFFF_FFFF, 4'd0, 1'b0, '0, 4'd3);
    row_chk(CMD_POP, '0, 4'd0, 1'b1, 32'hFFFF_FFFF, 4'd2);
    row(CMD_DRAIN, '0, 4'd15);
    row_cap(4'd1);
    row_chk(CMD_PUSH, 32'h8000_0001, 4'd0, 1'b1, '0, 4'd1);
    row_chk(CMD_PUSH, 32'h7FFF_FFFE, 4'd0, 1'b0, '0, 4'd1);
    row_chk(CMD_COUNT, '0, 4'd0, 1'b1, '0, 4'd1);
    row(CMD_DRAIN, '0, 4'd1);
    row(CMD_PUSH, 32'hDEAD_BEEF, 4'd0);
    // capacity write flushes the stored word; zero capacity refuses every push
    row_cap(4'd0);
    row_chk(CMD_PUSH, 32'h0000_0001, 4'd0, 1'b0, '0, 4'd0);
    row_chk(CMD_POP, '0, 4'd0, 1'b0, '0, 4'd0);
    row_chk(CMD_COUNT, '0, 4'd0, 1'b1, '0, 4'd0);
    row_chk(CMD_DRAIN, '0, 4'd15, 1'b0, '0, 4'd0);
    row_cap(4'd15);
    row(CMD_PUSH, 32'hAAAA_AAAA, 4'd0);
    row(CMD_PUSH, 32'h5555_5555, 4'd0);
    row(CMD_PUSH, 32'h0000_0001, 4'd0);
    row(CMD_PUSH, 32'h8000_0000, 4'd0);
    row(CMD_DRAIN, '0, 4'd3);
    row(CMD_POP, '0, 4'd0);
    row(CMD_COUNT, '0, 4'd0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < plan_len; i++) begin
      if (plan[i].is_cap) write_capacity(plan[i].cap);
      else send_cmd(plan[i].cmd, plan[i].data, plan[i].limit, plan[i].typed, plan[i].want);
    end

    items = 0;
    for (int p = 0; items < 380; p++) begin
      case (p)
        0: cap_pick = 4'd15;
        1: cap_pick = 4'd0;
        2: cap_pick = 4'd1;
        default: cap_pick = CAP_W'($urandom_range(0, 15));
      endcase
      write_capacity(cap_pick);
      calm_req = ($urandom_range(0, 4) == 0);
      calm_rsp = ($urandom_range(0, 4) == 0);
      // fill then empty, run near full, or stay balanced
      case ($urandom_range(0, 2))
        0: begin
          hi_pct = 85;
          lo_pct = 20;
        end
        1: begin
          hi_pct = 80;
          lo_pct = 60;
        end
        default: begin
          hi_pct = 45;
          lo_pct = 45;
        end
      endcase
      phase_len = (cap_pick == 0) ? 10 : $urandom_range(20, 45);
      for (int k = 0; k < phase_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < ((k < phase_len / 2) ? hi_pct : lo_pct)) begin
          c = CMD_PUSH;
        end else begin
          case ($urandom_range(0, 4))
            0, 1: c = CMD_POP;
            2, 3: c = CMD_DRAIN;
            default: c = CMD_COUNT;
          endcase
        end
        case ($urandom_range(0, 9))
          0: d = '0;
          1: d = '1;
          default: d = $urandom;
        endcase
        send_cmd(c, d, CNT_W'($urandom_range(0, 15)), 1'b0, '0);
        items++;
      end
    end

    req_if.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad_rsp == 0 && awaited_rsp.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
